/* rtl/rres_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rres_pkg: shared types and constants of the round-robin eligible select core
// Holds the ring size, field widths, status codes, controller states and the
// command and status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package rres_pkg;

   // Ring size and the widths that follow from it.
   localparam int MAX_SERVERS = 16;
   localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_W       = $clog2(MAX_SERVERS + 1);

   // Field widths of the beats.
   localparam int ID_W        = 16;
   localparam int ADDR_W      = 32;
   localparam int LOAD_W      = 7;
   localparam int RING_CNT_W  = 5;
   localparam int STATUS_W    = 2;
   localparam int REQ_DATA_W  = 56;
   localparam int RSP_DATA_W  = 64;

   // Load limit after reset.
   localparam logic [LOAD_W-1:0] LOAD_LIMIT_RESET = 7'd80;

   // Request kinds carried in req_tuser.
   localparam logic CMD_INSERT  = 1'b0;
   localparam logic CMD_REQUEST = 1'b1;

   // Result status codes carried in rsp_tuser.
   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_FULL      = 2'd1,
      ST_ALLOCATED = 2'd2,
      ST_NONE      = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_INSERT,
      S_SCAN,
      S_DONE
   } state_type;

   // One ring entry as stored.
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [ADDR_W-1:0] addr;
      logic              online;
      logic [LOAD_W-1:0] load;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic start_scan;
      logic do_insert;
      logic scan;
      logic finish;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_request;
      logic scan_done;
      logic out_free;
   } ctrl_stat_type;

endpackage

/* rtl/rres_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rres_ctrl: sequencing controller
// Accepts one beat at a time, steps through insert or ring scan, and hands the
// result to the output register once that register is free.
// ----------------------------------------------------------------------------
module rres_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  rres_pkg::ctrl_stat_type stat,
   output rres_pkg::ctrl_cmd_type  cmd
);

   rres_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rres_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rres_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = stat.is_request ? rres_pkg::S_SCAN : rres_pkg::S_INSERT;
            end
         end
         rres_pkg::S_INSERT: begin
            state_in = rres_pkg::S_DONE;
         end
         rres_pkg::S_SCAN: begin
            if (stat.scan_done) begin
               state_in = rres_pkg::S_DONE;
            end
         end
         rres_pkg::S_DONE: begin
            if (stat.out_free) begin
               state_in = rres_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rres_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs. The request kind is looked at straight from the incoming beat
   // in the idle state, so is_request reflects req_tuser there.
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         rres_pkg::S_IDLE: begin
            req_tready     = 1'b1;
            cmd.load_item  = req_tvalid;
            cmd.start_scan = req_tvalid;
         end
         rres_pkg::S_INSERT: begin
            cmd.do_insert = 1'b1;
         end
         rres_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
         end
         rres_pkg::S_DONE: begin
            cmd.finish = stat.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

/* rtl/rres_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rres_dpath: ring storage, scan pipeline and result registers
// Holds the entry memory, the fill count, the rotating pointer and the load
// limit. A scan reads one entry per cycle and tests the previous read.
// ----------------------------------------------------------------------------
module rres_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rres_pkg::ctrl_cmd_type                cmd,
   output rres_pkg::ctrl_stat_type               stat,
   // Incoming beat fields.
   input  logic                                  in_cmd,
   input  rres_pkg::entry_type                   in_entry,
   // Load limit write.
   input  logic                                  csr_we,
   input  logic [rres_pkg::LOAD_W-1:0]           csr_wdata,
   // Output register.
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output rres_pkg::status_type                  out_status,
   output logic [rres_pkg::ID_W-1:0]             out_id,
   output logic [rres_pkg::ADDR_W-1:0]           out_addr,
   output logic [rres_pkg::LOAD_W-1:0]           out_load,
   output logic [rres_pkg::RING_CNT_W-1:0]       out_count
);

   localparam int IDX_W = rres_pkg::IDX_W;
   localparam int CNT_W = rres_pkg::CNT_W;

   // Next ring position, wrapping to entry 0 after the last filled entry.
   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                 input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] inc;
      logic [IDX_W-1:0] res;
      inc = CNT_W'(i) + CNT_W'(1);
      if (inc >= n) begin
         res = '0;
      end else begin
         res = inc[IDX_W-1:0];
      end
      return res;
   endfunction

   rres_pkg::entry_type mem [rres_pkg::MAX_SERVERS];

   rres_pkg::entry_type           item_ff;
   logic [rres_pkg::LOAD_W-1:0]   limit_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [IDX_W-1:0]              ptr_ff;
   logic [IDX_W-1:0]              idx_ff;
   logic [IDX_W-1:0]              chk_idx_ff;
   logic                          chk_valid_ff;
   logic [CNT_W-1:0]              issued_ff;
   logic [CNT_W-1:0]              checked_ff;
   rres_pkg::entry_type           rd_ff;
   rres_pkg::status_type          res_status_ff;
   rres_pkg::entry_type           res_entry_ff;
   logic                          out_valid_ff;
   rres_pkg::status_type          out_status_ff;
   rres_pkg::entry_type           out_entry_ff;
   logic [rres_pkg::RING_CNT_W-1:0] out_count_ff;

   logic ring_full;
   logic issue_more;
   logic elig;
   logic last_check;
   logic hit;

   assign ring_full  = (count_ff == CNT_W'(rres_pkg::MAX_SERVERS));
   assign issue_more = (issued_ff != count_ff);
   assign elig       = rd_ff.online && (rd_ff.load < limit_ff);
   assign hit        = chk_valid_ff && elig;
   assign last_check = chk_valid_ff && ((checked_ff + CNT_W'(1)) == count_ff);

   // Status toward the controller.
   always_comb begin
      stat.is_request = (in_cmd == rres_pkg::CMD_REQUEST);
      stat.scan_done  = (count_ff == '0) || hit || last_check;
      stat.out_free   = !out_valid_ff || out_ready;
   end

   // Load limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= rres_pkg::LOAD_LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // Captured beat.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= in_entry;
      end
   end

   // Entry memory: one write port for inserts, one registered read port
   // that follows the scan index.
   always_ff @(posedge clock) begin
      if (cmd.do_insert && !ring_full) begin
         mem[count_ff[IDX_W-1:0]] <= item_ff;
      end
      rd_ff <= mem[idx_ff];
   end

   // Fill count and rotating pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         if (cmd.do_insert && !ring_full) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.scan && hit) begin
            ptr_ff <= next_idx(chk_idx_ff, count_ff);
         end
      end
   end

   // Scan pipeline: issue one read per cycle, test the entry read before.
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_valid_ff <= 1'b0;
      end else if (cmd.start_scan) begin
         chk_valid_ff <= 1'b0;
      end else if (cmd.scan) begin
         chk_valid_ff <= issue_more;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_scan) begin
         idx_ff     <= (CNT_W'(ptr_ff) >= count_ff) ? '0 : ptr_ff;
         issued_ff  <= '0;
         checked_ff <= '0;
      end else if (cmd.scan) begin
         if (issue_more) begin
            idx_ff     <= next_idx(idx_ff, count_ff);
            chk_idx_ff <= idx_ff;
            issued_ff  <= issued_ff + CNT_W'(1);
         end
         if (chk_valid_ff) begin
            checked_ff <= checked_ff + CNT_W'(1);
         end
      end
   end

   // Result staging for the item in flight.
   always_ff @(posedge clock) begin
      if (cmd.do_insert) begin
         res_status_ff <= ring_full ? rres_pkg::ST_FULL : rres_pkg::ST_INSERTED;
         res_entry_ff  <= '0;
      end else if (cmd.scan && stat.scan_done) begin
         if (hit) begin
            res_status_ff <= rres_pkg::ST_ALLOCATED;
            res_entry_ff  <= rd_ff;
         end else begin
            res_status_ff <= rres_pkg::ST_NONE;
            res_entry_ff  <= '0;
         end
      end
   end

   // Output register; it holds a result until the receiver takes the beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_status_ff <= res_status_ff;
         out_entry_ff  <= res_entry_ff;
         out_count_ff  <= rres_pkg::RING_CNT_W'(count_ff);
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_status = out_status_ff;
   assign out_id     = out_entry_ff.id;
   assign out_addr   = out_entry_ff.addr;
   assign out_load   = out_entry_ff.load;
   assign out_count  = out_count_ff;

endmodule

/* rtl/round_robin_eligible_select_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_eligible_select_core: round-robin server pick with eligibility
// Usage:
//   req_*  : request beats. req_tuser = 0 inserts the server entry carried in
//            req_tdata at the end of the ring; req_tuser = 1 asks for the next
//            eligible server (online, load below the programmed limit).
//   rsp_*  : one result beat per request beat, in order, status in rsp_tuser.
//   csr_*  : write of the load limit; always ready; write only while idle.
// Sequence: an insert passes the insert and done states before its result
//   is in the output register; a request scans from the pointer until a
//   hit or the last filled entry, or finds an empty ring, then passes done.
//   The scan reads one entry per cycle and tests it in the next cycle.
// Flow: one beat at a time; the next is taken in the idle state that
//   follows the loading of the result.
// Reset: synchronous; the ring is emptied, the pointer goes to entry 0 and
//   the load limit to 80. Entry contents are not cleared.
// Stall: a finished result waits in the output register while rsp_tready is
//   low; the next beat is accepted and worked on meanwhile, and is held at
//   completion until the output register frees up.
// ----------------------------------------------------------------------------
module round_robin_eligible_select_core (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: server_id[15:0], server_addr[47:16], online[48], load_pct[55:49]
   input  logic [rres_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: cmd[0]
   input  logic                                req_tuser,
   // Result channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: chosen_id[15:0], chosen_addr[47:16], chosen_load[54:48],
   //        ring_count[59:55], zero[63:60]
   output logic [rres_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser: status[1:0]
   output logic [rres_pkg::STATUS_W-1:0]       rsp_tuser,
   // Load limit write.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rres_pkg::LOAD_W-1:0]         csr_data
);

   rres_pkg::ctrl_cmd_type  cmd;
   rres_pkg::ctrl_stat_type stat;
   rres_pkg::entry_type     in_entry;
   rres_pkg::status_type    out_status;

   logic [rres_pkg::ID_W-1:0]       out_id;
   logic [rres_pkg::ADDR_W-1:0]     out_addr;
   logic [rres_pkg::LOAD_W-1:0]     out_load;
   logic [rres_pkg::RING_CNT_W-1:0] out_count;

   // Unpack the request beat.
   always_comb begin
      in_entry.id     = req_tdata[15:0];
      in_entry.addr   = req_tdata[47:16];
      in_entry.online = req_tdata[48];
      in_entry.load   = req_tdata[55:49];
   end

   assign csr_ready = 1'b1;

   rres_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rres_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_cmd     (req_tuser),
      .in_entry   (in_entry),
      .csr_we     (csr_valid && csr_ready),
      .csr_wdata  (csr_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (out_status),
      .out_id     (out_id),
      .out_addr   (out_addr),
      .out_load   (out_load),
      .out_count  (out_count)
   );

   // Pack the result beat.
   assign rsp_tuser = out_status;
   assign rsp_tdata = {4'd0, out_count, out_load, out_addr, out_id};

   // A beat taken in starts a busy period; no second beat in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted back to back");

   // The ring never reports more entries than its size of MAX_SERVERS.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[59:55] <= rres_pkg::RING_CNT_W'(rres_pkg::MAX_SERVERS)))
      else $error("ring count above ring size");

   // Only an allocation carries a chosen server.
   a_chosen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != rres_pkg::ST_ALLOCATED)) |-> (rsp_tdata[54:0] == '0))
      else $error("chosen fields set without allocation");

endmodule

/* verif/round_robin_eligible_select_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_eligible_select_core_test: self-checking bench for the selector
// A directed table first builds the ring from empty to full. On the way it
// touches the empty-ring request, field extremes, offline entries, loads on
// both sides of the limit, limits of 0, 101 and 127, and an insert into a
// full ring. Random phases follow, each under a new load limit, mixing
// requests with dropped inserts. Every result beat is compared with a
// cycle-free predictor of the ring, while both channels stall at random.
// ----------------------------------------------------------------------------
module round_robin_eligible_select_core_test;
   import rres_pkg::*;

   localparam int SETTLE_CYCLES  = 24;   // worst request latency plus margin
   localparam int RANDOM_PHASES  = 16;
   localparam int PHASE_BEATS    = 60;
   localparam int QUIET_PHASES   = 3;    // last phases run without idling
   localparam int LONG_HOLD      = 300;  // receiver hold-off, in cycles
   localparam int REPORT_LIMIT   = 10;
   localparam int DIR_ROWS       = 29;

   // One request beat, as it is packed onto req_tdata and req_tuser.
   typedef struct packed {
      logic              cmd;
      logic [ID_W-1:0]   id;
      logic [ADDR_W-1:0] addr;
      logic              online;
      logic [LOAD_W-1:0] load;
   } beat_type;

   // One result beat; pad holds the upper tdata bits that must stay zero.
   typedef struct packed {
      status_type            status;
      logic [3:0]            pad;
      logic [RING_CNT_W-1:0] count;
      logic [LOAD_W-1:0]     load;
      logic [ADDR_W-1:0]     addr;
      logic [ID_W-1:0]       id;
   } result_type;

   typedef enum logic {ROW_BEAT, ROW_LIMIT} row_kind_type;

   // Directed row. A limit row carries the new limit in load. Where typed is
   // set, the result is status and ring count with all chosen fields zero.
   typedef struct packed {
      row_kind_type          kind;
      logic                  cmd;
      logic [ID_W-1:0]       id;
      logic [ADDR_W-1:0]     addr;
      logic                  online;
      logic [LOAD_W-1:0]     load;
      logic                  typed;
      status_type            exp_status;
      logic [RING_CNT_W-1:0] exp_count;
   } dir_row_type;

   dir_row_type dir_rows [DIR_ROWS] = '{
      // Request on the empty ring.
      '{ROW_BEAT,  CMD_REQUEST, 16'h0000, 32'h00000000, 1'b0, 7'd0,   1'b1, ST_NONE,      5'd0},
      '{ROW_BEAT,  CMD_INSERT,  16'h0000, 32'h00000000, 1'b1, 7'd0,   1'b1, ST_INSERTED,  5'd1},
      '{ROW_BEAT,  CMD_REQUEST, 16'h0000, 32'h00000000, 1'b0, 7'd0,   1'b0, ST_NONE,      5'd0},
      '{ROW_BEAT,  CMD_INSERT,  16'hFFFF, 32'hFFFFFFFF, 1'b1, 7'd127, 1'b1, ST_INSERTED,  5'd2},
      '{ROW_BEAT,  CMD_INSERT,  16'h1234, 32'hC0A80001, 1'b0, 7'd10,  1'b1, ST_INSERTED,  5'd3},
      '{ROW_BEAT,  CMD_REQUEST, 16'hFFFF, 32'hFFFFFFFF, 1'b1, 7'd127, 1'b0, ST_NONE,      5'd0},
      '{ROW_BEAT,  CMD_REQUEST, 16'h0000, 32'h00000000, 1'b0, 7'd0,   1'b0, ST_NONE,      5'd0},
      '{ROW_BEAT,  CMD_INSERT,  16'h0005, 32'h0A000005, 1'b1, 7'd79,  1'b1, ST_INSERTED,  5'd4},
      '{ROW_BEAT,  CMD_INSERT,  16'h0006, 32'h0A000006, 1'b1, 7'd80,  1'b1, ST_INSERTED,  5'd5},
      // A limit of zero makes every entry ineligible.
      '{ROW_LIMIT, CMD_INSERT,  16'h0000, 32'h00000000, 1'b0, 7'd0,   1'b0, ST_NONE,      5'd0},
      '{ROW_BEAT,  CMD_REQUEST, 16'h0000, 32'h00000000, 1'b0, 7'd0,   1'b1, ST_NONE,      5'd5},
      '{ROW_LIMIT, CMD_INSERT,  16'h0000, 32'h00000000, 1'b0, 7'd101, 1'b0, ST_NONE,      5'd0},
      '{ROW_BEAT,  CMD_REQUEST, 16'h0000, 32'h00000000, 1'b0, 7'd0,   1'b0, ST_NONE,      5'd0},
      '{ROW_LIMIT, CMD_INSERT,  16'h0000, 32'h00000000, 1'b0, 7'd127, 1'b0, ST_NONE,      5'd0},
      // Fill the rest of the ring.
      '{ROW_BEAT,  CMD_INSERT,  16'h8001, 32'h7F000001, 1'b1, 7'd100, 1'b1, ST_INSERTED,  5'd6},
      '{ROW_BEAT,  CMD_INSERT,  16'h00FF, 32'h01020304, 1'b0, 7'd0,   1'b1, ST_INSERTED,  5'd7},
      '{ROW_BEAT,  CMD_INSERT,  16'hAAAA, 32'hAAAAAAAA, 1'b1, 7'd50,  1'b1, ST_INSERTED,  5'd8},
      '{ROW_BEAT,  CMD_INSERT,  16'h5555, 32'h55555555, 1'b1, 7'd85,  1'b1, ST_INSERTED,  5'd9},
      '{ROW_BEAT,  CMD_INSERT,  16'h0100, 32'hFFFF0000, 1'b0, 7'd99,  1'b1, ST_INSERTED,  5'd10},
      '{ROW_BEAT,  CMD_INSERT,  16'h0200, 32'h0000FFFF, 1'b1, 7'd101, 1'b1, ST_INSERTED,  5'd11},
      '{ROW_BEAT,  CMD_INSERT,  16'h0300, 32'h80000000, 1'b1, 7'd1,   1'b1, ST_INSERTED,  5'd12},
      '{ROW_BEAT,  CMD_INSERT,  16'h0400, 32'h00000001, 1'b0, 7'd64,  1'b1, ST_INSERTED,  5'd13},
      '{ROW_BEAT,  CMD_INSERT,  16'h0500, 32'hDEADBEEF, 1'b1, 7'd126, 1'b1, ST_INSERTED,  5'd14},
      '{ROW_BEAT,  CMD_INSERT,  16'h0600, 32'h12345678, 1'b1, 7'd30,  1'b1, ST_INSERTED,  5'd15},
      '{ROW_BEAT,  CMD_INSERT,  16'h7FFF, 32'hFEDCBA98, 1'b1, 7'd95,  1'b1, ST_INSERTED,  5'd16},
      // Insert into the full ring is dropped.
      '{ROW_BEAT,  CMD_INSERT,  16'hFFFF, 32'hFFFFFFFF, 1'b1, 7'd127, 1'b1, ST_FULL,      5'd16},
      '{ROW_BEAT,  CMD_REQUEST, 16'h0000, 32'h00000000, 1'b0, 7'd0,   1'b0, ST_NONE,      5'd0},
      '{ROW_LIMIT, CMD_INSERT,  16'h0000, 32'h00000000, 1'b0, 7'd80,  1'b0, ST_NONE,      5'd0},
      '{ROW_BEAT,  CMD_REQUEST, 16'h0000, 32'h00000000, 1'b0, 7'd0,   1'b0, ST_NONE,      5'd0}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [LOAD_W-1:0]     csr_data;

   // Predictor state: the ring, its size, the rotating pointer and the limit.
   entry_type         ring_entry [MAX_SERVERS];
   int                ring_size;
   int                rr_next;
   logic [LOAD_W-1:0] limit_now;

   result_type pending_picks [$];
   int         mismatches;
   int         beats_sent;
   int         limit_writes;
   int         n_alloc;
   int         n_none;
   int         n_full;
   int         n_insert;
   bit         idle_on;
   int         hold_rsp_cycles;

   round_robin_eligible_select_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d results still outstanding.", pending_picks.size());
      $display("FAILED: results differ");
      $finish;
   end

   // Work out the result of one beat and advance the ring state.
   function automatic result_type pick_server(input beat_type b);
      result_type res;
      int         n;
      int         idx;
      bit         found;
      res = '0;
      if (b.cmd == CMD_INSERT) begin
         if (ring_size >= MAX_SERVERS) begin
            res.status = ST_FULL;
         end else begin
            ring_entry[ring_size] = '{b.id, b.addr, b.online, b.load};
            ring_size++;
            res.status = ST_INSERTED;
         end
      end else begin
         res.status = ST_NONE;
         n = ring_size;
         idx = rr_next;
         found = 1'b0;
         if (n > 0 && idx >= n) idx = 0;
         // Scan at most one turn from the pointer for an eligible entry.
         for (int k = 0; k < n && !found; k++) begin
            if (ring_entry[idx].online && ring_entry[idx].load < limit_now) begin
               found = 1'b1;
               res.status = ST_ALLOCATED;
               res.id = ring_entry[idx].id;
               res.addr = ring_entry[idx].addr;
               res.load = ring_entry[idx].load;
               rr_next = (idx + 1 >= n) ? 0 : idx + 1;
            end else begin
               idx = (idx + 1 >= n) ? 0 : idx + 1;
            end
         end
      end
      res.count = RING_CNT_W'(ring_size);
      return res;
   endfunction

   // Offer one beat, with a random gap first when idling is on.
   task automatic send_beat(input beat_type b, input bit typed,
                            input status_type t_status,
                            input logic [RING_CNT_W-1:0] t_count);
      result_type want;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= b.cmd;
      req_tdata  <= {b.load, b.online, b.addr, b.id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = pick_server(b);
      if (typed) begin
         want = '0;
         want.status = t_status;
         want.count = t_count;
      end
      pending_picks.push_back(want);
      beats_sent++;
   endtask

   // Stop offering beats and wait until every expected result has come.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_picks.size() != 0) @(posedge clock);
   endtask

   // Program the load limit once the block has gone idle.
   task automatic set_limit(input logic [LOAD_W-1:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      limit_now = value;
      limit_writes++;
   endtask

   // Result receiver: random stalls, plus one long hold-off on request.
   initial begin : rsp_sink
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_rsp_cycles) @(posedge clock);
            hold_rsp_cycles = 0;
            rsp_tready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare every accepted result beat with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = status_type'(rsp_tuser);
         {got.pad, got.count, got.load, got.addr, got.id} = rsp_tdata;
         if (pending_picks.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $display("%0t: result beat with none expected: status %0d tdata %h",
                        $realtime, got.status, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_picks.pop_front();
            case (want.status)
               ST_ALLOCATED: n_alloc++;
               ST_NONE:      n_none++;
               ST_FULL:      n_full++;
               default:      n_insert++;
            endcase
            if (got !== want) begin
               if (mismatches < REPORT_LIMIT) begin
                  $display("%0t: mismatch, expected status %0d id %h addr %h load %0d count %0d pad %h",
                           $realtime, want.status, want.id, want.addr, want.load,
                           want.count, want.pad);
                  $display("%0t:           actual status %0d id %h addr %h load %0d count %0d pad %h",
                           $realtime, got.status, got.id, got.addr, got.load,
                           got.count, got.pad);
               end
               mismatches++;
            end
         end
      end
   end

   // Stimulus: reset, directed table, then random phases.
   initial begin : stimulus
      beat_type          b;
      logic [LOAD_W-1:0] sweep_limits [6];
      sweep_limits = '{7'd0, 7'd127, 7'd101, 7'd1, 7'd100, 7'd80};
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_INSERT;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      ring_size = 0;
      rr_next = 0;
      limit_now = LOAD_LIMIT_RESET;
      mismatches = 0;
      beats_sent = 0;
      limit_writes = 0;
      n_alloc = 0;
      n_none = 0;
      n_full = 0;
      n_insert = 0;
      hold_rsp_cycles = 0;
      idle_on = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_LIMIT) begin
            set_limit(dir_rows[i].load);
         end else begin
            b = '{dir_rows[i].cmd, dir_rows[i].id, dir_rows[i].addr,
                  dir_rows[i].online, dir_rows[i].load};
            send_beat(b, dir_rows[i].typed, dir_rows[i].exp_status,
                      dir_rows[i].exp_count);
         end
      end

      // Random phases on the full ring, each under its own limit.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_limit((p < 6) ? sweep_limits[p] : LOAD_W'($urandom_range(0, 127)));
         idle_on = (p < RANDOM_PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);
         // Hold the receiver off so the block backs up and stalls its input.
         if (p == 2) begin
            idle_on = 1'b0;
            hold_rsp_cycles = LONG_HOLD;
         end
         for (int k = 0; k < PHASE_BEATS; k++) begin
            // Once, the sender pauses mid-phase until all results are back.
            if (p == 4 && k == PHASE_BEATS / 2) drain_results();
            b.cmd = ($urandom_range(0, 4) == 0) ? CMD_INSERT : CMD_REQUEST;
            b.id = ID_W'($urandom);
            b.addr = $urandom;
            b.online = 1'($urandom_range(0, 1));
            b.load = ($urandom_range(0, 3) == 0) ? LOAD_W'($urandom_range(0, 127))
                                                 : LOAD_W'($urandom_range(0, 100));
            send_beat(b, 1'b0, ST_NONE, '0);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_picks.size() != 0) mismatches++;

      $display("Run covered %0d beats under %0d limit writes: %0d inserts, %0d drops on a full ring,",
               beats_sent, limit_writes, n_insert, n_full);
      $display("%0d allocations and %0d requests with no eligible server; %0d mismatches.",
               n_alloc, n_none, mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/rres_pkg.sv
rtl/rres_ctrl.sv
rtl/rres_dpath.sv
rtl/round_robin_eligible_select_core.sv
verif/round_robin_eligible_select_core_test.sv
